### sv/ttceb_pkg.sv
// Shared types, constants and the cosine table builder for the TTC brake block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttceb_pkg;

    localparam int COS_TABLE_BITS = 10;
    localparam int COS_FRAC_BITS  = 15;
    localparam int QUARTER_N      = 1 << COS_TABLE_BITS;
    localparam int COS_W          = COS_FRAC_BITS + 1;      // table entry, 0..2^F
    localparam int COS_S_W        = COS_FRAC_BITS + 2;      // signed cosine
    localparam int ROM_AW         = COS_TABLE_BITS + 1;     // 0..QUARTER_N

    localparam int RANGE_W   = 16;
    localparam int SPEED_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int NEAR_W    = 17;
    localparam int PROD_W    = SPEED_W + COS_S_W;           // speed * cos
    localparam int RHS_W     = CFG_W + PROD_W - 1;          // limit * positive product
    localparam int MM1000_W  = RANGE_W + 10;                // range * 1000
    localparam int LHS_W     = MM1000_W + COS_FRAC_BITS;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [NEAR_W-1:0] NEAR_NONE = {NEAR_W{1'b1}};

    localparam logic PI_OP_BEAM    = 1'b0;
    localparam logic PI_OP_RELEASE = 1'b1;

    typedef enum logic [2:0]
    {
        REG_ANGLE_START      = 3'd0,
        REG_ANGLE_STEP       = 3'd1,
        REG_RANGE_FLOOR      = 3'd2,
        REG_RANGE_CEILING    = 3'd3,
        REG_TTC_LIMIT_MS     = 3'd4,
        REG_RELEASE_DISTANCE = 3'd5
    } reg_idx_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] angle_start;
        logic [CFG_W-1:0] angle_step;
        logic [CFG_W-1:0] range_floor;
        logic [CFG_W-1:0] range_ceiling;
        logic [CFG_W-1:0] ttc_limit_ms;
        logic [CFG_W-1:0] release_distance;
    } cfg_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load;      // input transfer this cycle
        logic rom_rd;    // cosine table read
        logic mul;       // speed * cos
        logic mul2;      // limit * rate, range * 1000
        logic acc;       // threat and nearest update
        logic emit;      // load output register, apply scan decision
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic in_release;   // opcode of the item on the input bus
        logic is_last;      // held item closes a scan
        logic out_free;     // output register can take a result now
    } dp_status_t;

    typedef logic [COS_W-1:0] cos_rom_t [0:QUARTER_N];

    localparam int COS_DIV [0:6] = '{2, 12, 30, 56, 90, 132, 182};

    // Taylor series of cos over the first quadrant, Q30 internally.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        for (int k = 0; k <= QUARTER_N; k++)
        begin
            x    = (64'd1686629713 * 64'(k)) >> COS_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 0; n < 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'(COS_DIV[n]);
                if (n % 2 == 1)
                    sum = sum + longint'(term);
                else
                    sum = sum - longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (sum + (longint'(1) << (29 - COS_FRAC_BITS))) >>> (30 - COS_FRAC_BITS);
            if (v > (longint'(1) << COS_FRAC_BITS))
                v = longint'(1) << COS_FRAC_BITS;
            rom[k] = COS_W'(v);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### sv/ttceb_cfg.sv
// APB register file for the TTC brake block: six 16-bit registers.
// Depends on ttceb_pkg.
`default_nettype none

module ttceb_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ttceb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ttceb_pkg::PDATA_W-1:0] pwdata,
    output logic      [ttceb_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output ttceb_pkg::cfg_t                    cfg
);
    import ttceb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_idx_t   idx;
    logic       wr_en;
    logic [CFG_W-1:0] wdata;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[CFG_W-1:0];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ANGLE_START:      cfg_next.angle_start      = wdata;
                REG_ANGLE_STEP:       cfg_next.angle_step       = wdata;
                REG_RANGE_FLOOR:      cfg_next.range_floor      = wdata;
                REG_RANGE_CEILING:    cfg_next.range_ceiling    = wdata;
                REG_TTC_LIMIT_MS:     cfg_next.ttc_limit_ms     = wdata;
                REG_RELEASE_DISTANCE: cfg_next.release_distance = wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ANGLE_START:      prdata = PDATA_W'(cfg_reg.angle_start);
            REG_ANGLE_STEP:       prdata = PDATA_W'(cfg_reg.angle_step);
            REG_RANGE_FLOOR:      prdata = PDATA_W'(cfg_reg.range_floor);
            REG_RANGE_CEILING:    prdata = PDATA_W'(cfg_reg.range_ceiling);
            REG_TTC_LIMIT_MS:     prdata = PDATA_W'(cfg_reg.ttc_limit_ms);
            REG_RELEASE_DISTANCE: prdata = PDATA_W'(cfg_reg.release_distance);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_start      <= '0;
            cfg_reg.angle_step       <= '0;
            cfg_reg.range_floor      <= '0;
            cfg_reg.range_ceiling    <= 16'd65535;
            cfg_reg.ttc_limit_ms     <= 16'd400;
            cfg_reg.release_distance <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### sv/ttceb_ctrl.sv
// TTC brake sequencer, depends on ttceb_pkg: walks one beam through table read,
// two multiply stages, accumulate and, at scan end, result; a release skips to result.
`default_nettype none

module ttceb_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire ttceb_pkg::dp_status_t  status,
    output ttceb_pkg::ctrl_cmd_t        cmd
);
    import ttceb_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROM,
        ST_MUL,
        ST_MUL2,
        ST_ACC,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_release ? ST_RESULT : ST_ROM;
                end
            end
            ST_ROM:
            begin
                cmd.rom_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.is_last ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### sv/ttceb_dp.sv
// Datapath of the TTC brake block: angle tracking, cosine table, closing-rate
// and threat arithmetic, scan state, brake latch, output register. Uses ttceb_pkg.
`default_nettype none

module ttceb_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ttceb_pkg::cfg_t                 cfg,
    input  wire ttceb_pkg::ctrl_cmd_t            cmd,
    output ttceb_pkg::dp_status_t                status,
    input  wire logic [ttceb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [ttceb_pkg::M_TDATA_W-1:0] m_tdata
);
    import ttceb_pkg::*;

    localparam cos_rom_t COS_ROM = build_cos_rom();

    // held item
    logic                        op_reg;
    logic [RANGE_W-1:0]          range_reg;
    logic                        nf_reg;
    logic signed [SPEED_W-1:0]   speed_reg;
    logic                        last_reg;
    logic [ANGLE_W-1:0]          angle_reg;

    // scan state
    logic [ANGLE_W-1:0]          beam_angle_reg;
    logic                        fresh_reg;
    logic                        threat_reg;
    logic [NEAR_W-1:0]           near_reg;
    logic                        latch_reg;

    // arithmetic pipeline
    logic [COS_W-1:0]            rom_q_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [RHS_W-1:0]            rhs_reg;
    logic [LHS_W-1:0]            lhs_reg;
    logic                        pos_reg;

    // output register
    logic                        out_valid_reg;
    logic                        out_active_reg;
    logic                        out_trig_reg;
    logic [RANGE_W-1:0]          out_near_reg;

    logic [ANGLE_W-1:0]          angle_cur;
    logic [1:0]                  quad;
    logic [COS_TABLE_BITS-1:0]   tab_i;
    logic [ROM_AW-1:0]           rom_addr;
    logic signed [COS_S_W-1:0]   cos_mag;
    logic signed [COS_S_W-1:0]   cos_s;
    logic [MM1000_W-1:0]         mm1000;
    logic                        in_window;
    logic                        threat_now;
    logic                        trig;
    logic                        latch_next;
    logic [RANGE_W-1:0]          near_sat;

    assign angle_cur = fresh_reg ? cfg.angle_start : beam_angle_reg;

    // quadrant from the top two bits, truncated index below
    assign quad     = angle_reg[ANGLE_W-1 -: 2];
    assign tab_i    = angle_reg[ANGLE_W-3 -: COS_TABLE_BITS];
    assign rom_addr = quad[0] ? (ROM_AW'(QUARTER_N) - {1'b0, tab_i}) : {1'b0, tab_i};
    assign cos_mag  = $signed({1'b0, rom_q_reg});
    assign cos_s    = (quad[1] ^ quad[0]) ? -cos_mag : cos_mag;

    assign mm1000    = MM1000_W'(range_reg) * MM1000_W'(1000);
    assign in_window = (range_reg >= cfg.range_floor) && (range_reg <= cfg.range_ceiling);
    assign threat_now = !nf_reg && in_window && pos_reg && (RHS_W'(lhs_reg) < rhs_reg);

    assign trig       = threat_reg && !latch_reg;
    assign latch_next = threat_reg ? 1'b1
                      : (near_reg > NEAR_W'(cfg.release_distance)) ? 1'b0 : latch_reg;
    assign near_sat   = near_reg[NEAR_W-1] ? {RANGE_W{1'b1}} : near_reg[RANGE_W-1:0];

    assign status.in_release = (s_tuser == PI_OP_RELEASE);
    assign status.is_last    = last_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RANGE_W - 2){1'b0}}, out_near_reg, out_trig_reg,
                       out_active_reg};

    // payload, arithmetic and output data registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= s_tuser;
            range_reg <= s_tdata[RANGE_W-1:0];
            nf_reg    <= s_tdata[RANGE_W];
            speed_reg <= $signed(s_tdata[RANGE_W+1 +: SPEED_W]);
            last_reg  <= s_tlast;
            angle_reg <= angle_cur;
        end
        if (cmd.rom_rd)
            rom_q_reg <= COS_ROM[rom_addr];
        if (cmd.mul)
            prod_reg <= PROD_W'(speed_reg) * PROD_W'(cos_s);
        if (cmd.mul2)
        begin
            rhs_reg <= RHS_W'(cfg.ttc_limit_ms) * RHS_W'(prod_reg[PROD_W-2:0]);
            lhs_reg <= {mm1000, {COS_FRAC_BITS{1'b0}}};
            pos_reg <= !prod_reg[PROD_W-1] && (prod_reg != '0);
        end
        if (cmd.emit)
        begin
            if (op_reg == PI_OP_RELEASE)
            begin
                out_active_reg <= 1'b0;
                out_trig_reg   <= 1'b0;
                out_near_reg   <= {RANGE_W{1'b1}};
            end
            else
            begin
                out_active_reg <= latch_next;
                out_trig_reg   <= trig;
                out_near_reg   <= near_sat;
            end
        end
    end

    // scan state, latch and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_angle_reg <= '0;
            fresh_reg      <= 1'b1;
            threat_reg     <= 1'b0;
            near_reg       <= NEAR_NONE;
            latch_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && (s_tuser == PI_OP_BEAM))
            begin
                beam_angle_reg <= angle_cur + cfg.angle_step;
                fresh_reg      <= 1'b0;
            end
            if (cmd.acc && !nf_reg)
            begin
                if (NEAR_W'(range_reg) < near_reg)
                    near_reg <= NEAR_W'(range_reg);
                if (threat_now)
                    threat_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == PI_OP_RELEASE)
                begin
                    latch_reg <= 1'b0;
                end
                else
                begin
                    latch_reg  <= latch_next;
                    threat_reg <= 1'b0;
                    near_reg   <= NEAR_NONE;
                    fresh_reg  <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/ttc_emergency_brake_top.sv
// Top level of the time-to-collision emergency brake block.
// Instantiates ttceb_cfg, ttceb_ctrl and ttceb_dp; depends on ttceb_pkg.
//
//  channel  | direction | transfer moves
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | one lidar beam or an operator release command
//  m_*      | out       | brake decision at scan end or after a release
//  APB      | in/out    | six 16-bit registers at byte addresses 0..20
//
// A beam goes through input transfer, table read, rate multiply, limit
// multiply and compare/accumulate; the one closing a scan then loads the
// output register once it is free. A release command goes from the input
// transfer to that load. The sequencer holds one item at a time.
// Reset clears the brake latch, the scan state and the output valid; the
// output register lets the next item in while a result waits on m_tready.
`default_nettype none

module ttc_emergency_brake_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // beam stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] range_mm, [16] not_finite, [32:17] speed_mm_s, [39:33] zero
    input  wire logic [ttceb_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode (0 beam, 1 operator release)
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,    // scan_end
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] brake_active, [1] brake_triggered, [17:2] nearest_mm, [23:18] zero
    output logic      [ttceb_pkg::M_TDATA_W-1:0] m_tdata,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ttceb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ttceb_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ttceb_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready
);
    import ttceb_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    ttceb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns s_tready, issues one command per stage
    ttceb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, scan accumulation, latch and output register
    ttceb_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
